>>> hdl/gbte_pkg.sv
`timescale 1ns / 1ps
package gbte_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_COUNT    = 2'd0;
  localparam logic [1:0] REQ_FINISH   = 2'd1;
  localparam logic [1:0] REQ_CLASSIFY = 2'd2;
  localparam logic [1:0] REQ_RSVD     = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SETS = 3'd0;
  localparam logic [2:0] REG_INCL = 3'd1;
  localparam logic [2:0] REG_REV  = 3'd2;
  localparam logic [2:0] REG_XOFF = 3'd3;
  localparam logic [2:0] REG_YOFF = 3'd4;

  localparam int BIN_W = 25;
  localparam int TOT_W = 33;
  localparam logic [BIN_W-1:0] BIN_MAX = '1;
  localparam logic [8:0] LEVEL_END = 9'd256;

  // Controller states; each state issues the datapath operation of the same name.
  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_CNT_RD, OP_CNT_WR,
    OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_WR, OP_DECIDE,
    OP_INIT_RD, OP_INIT_WR, OP_INIT_END,
    OP_G_START, OP_G_LOAD, OP_G_RD, OP_G_SUM, OP_G_CALC, OP_G_END,
    OP_T_START, OP_T_RD1, OP_T_RD2, OP_T_WR, OP_T_POST, OP_F_MASK,
    OP_M_START, OP_M_RD, OP_M_CALC,
    OP_E_START, OP_E_SCAN, OP_E_LOAD, OP_E_WAIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic ct_zero;
    logic grouped;
    logic init_last;
    logic g_last;
    logic moved;
    logic t_last;
    logic active_zero;
    logic m_last;
    logic mask_zero;
    logic mask_hit;
    logic out_taken;
  } status_t;

endpackage

>>> hdl/gbte_ctrl.sv
`timescale 1ns / 1ps
module gbte_ctrl import gbte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] req_type,
  input  status_t    st,
  output logic       in_stall,
  output cmd_t       cmd
);

  op_t state, state_next;

  // State register; reset starts the histogram clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= OP_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command to the datapath.
  always_comb begin
    state_next = state;
    cmd.op     = state;
    cmd.accept = 1'b0;
    in_stall   = (state != OP_IDLE);
    case (state)
      OP_CLEAR: begin
        if (st.idx_last) state_next = OP_IDLE;
      end
      OP_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (req_type)
            REQ_COUNT:    state_next = OP_CNT_RD;
            REQ_FINISH:   state_next = OP_SCAN_INIT;
            REQ_CLASSIFY: state_next = OP_M_START;
            default:      state_next = OP_IDLE;
          endcase
        end
      end
      OP_CNT_RD:    state_next = OP_CNT_WR;
      OP_CNT_WR:    state_next = OP_IDLE;
      OP_SCAN_INIT: state_next = OP_SCAN_RD;
      OP_SCAN_RD:   state_next = OP_SCAN_WR;
      OP_SCAN_WR: begin
        state_next = st.idx_last ? OP_DECIDE : OP_SCAN_RD;
      end
      OP_DECIDE: begin
        if (st.ct_zero) state_next = OP_IDLE;
        else if (st.grouped) state_next = OP_INIT_RD;
        else state_next = OP_T_START;
      end
      OP_INIT_RD:  state_next = OP_INIT_WR;
      OP_INIT_WR:  state_next = st.init_last ? OP_INIT_END : OP_INIT_RD;
      OP_INIT_END: state_next = OP_G_START;
      OP_G_START:  state_next = OP_G_LOAD;
      OP_G_LOAD:   state_next = OP_G_RD;
      OP_G_RD:     state_next = OP_G_SUM;
      OP_G_SUM:    state_next = OP_G_CALC;
      OP_G_CALC:   state_next = st.g_last ? OP_G_END : OP_G_RD;
      OP_G_END:    state_next = st.moved ? OP_G_START : OP_T_START;
      OP_T_START:  state_next = OP_T_RD1;
      OP_T_RD1:    state_next = OP_T_RD2;
      OP_T_RD2:    state_next = OP_T_WR;
      OP_T_WR:     state_next = st.t_last ? OP_T_POST : OP_T_RD1;
      OP_T_POST:   state_next = OP_F_MASK;
      OP_F_MASK:   state_next = OP_E_START;
      OP_M_START:  state_next = st.active_zero ? OP_IDLE : OP_M_RD;
      OP_M_RD:     state_next = OP_M_CALC;
      OP_M_CALC:   state_next = st.m_last ? OP_E_START : OP_M_RD;
      OP_E_START:  state_next = st.mask_zero ? OP_IDLE : OP_E_SCAN;
      OP_E_SCAN: begin
        if (st.mask_hit) state_next = OP_E_LOAD;
      end
      OP_E_LOAD:   state_next = OP_E_WAIT;
      OP_E_WAIT: begin
        if (st.out_taken) state_next = st.mask_zero ? OP_IDLE : OP_E_SCAN;
      end
      default:     state_next = OP_IDLE;
    endcase
  end

endmodule

>>> hdl/gbte_dp.sv
`timescale 1ns / 1ps
module gbte_dp import gbte_pkg::*; #(
  parameter int MAX_SETS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         req_type,
  input  logic [23:0]        pixel_color,
  input  logic [11:0]        pixel_column,
  input  logic [11:0]        pixel_row,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               result_kind,
  output logic [3:0]         set_index,
  output logic [8:0]         band_low,
  output logic [8:0]         band_high,
  output logic signed [16:0] coord_x,
  output logic signed [16:0] coord_y,
  output logic               last_item
);

  localparam int AW  = $clog2(MAX_SETS + 1);
  localparam int CW  = $clog2(MAX_SETS + 2);
  localparam int TCW = $clog2(MAX_SETS + 3);
  localparam int EW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int GD  = MAX_SETS + 1;
  localparam int TD  = MAX_SETS + 2;

  // Configuration registers.
  logic [4:0]  cfg_sets;
  logic        incl, rev;
  logic [15:0] xoff, yoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sets <= 5'd1;
      incl     <= 1'b0;
      rev      <= 1'b0;
      xoff     <= '0;
      yoff     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETS: cfg_sets <= cfg_data[4:0];
        REG_INCL: incl     <= cfg_data[0];
        REG_REV:  rev      <= cfg_data[0];
        REG_XOFF: xoff     <= cfg_data;
        REG_YOFF: yoff     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [1:0]  req;
  logic [7:0]  gray;
  logic [11:0] col, row;
  logic [15:0] gray_sum;

  assign gray_sum = 16'(pixel_color[23:16]) * 16'd77 + 16'(pixel_color[15:8]) * 16'd154
                  + 16'(pixel_color[7:0]) * 16'd25;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req  <= req_type;
      gray <= gray_sum[15:8];
      col  <= pixel_column;
      row  <= pixel_row;
    end
  end

  // Working registers.
  logic [8:0]       idx, ct;
  logic             bin0, grouped, moved, pre;
  logic [AW-1:0]    nsets, active;
  logic [CW-1:0]    gi, m;
  logic [7:0]       cur_b;
  logic [TOT_W-1:0] prev_tot, left_r, right_r;
  logic [TCW-1:0]   total;
  logic [MAX_SETS-1:0] mask;
  logic [EW-1:0]    ei;

  logic [CW-1:0] nb, nbm1, k, m_v, s_v;
  logic [TCW-1:0] tot_v, top;
  logic           pre_v, post_v, skip, hit;
  logic [8:0]     next9, b1, t_val;
  logic [AW-1:0]  clamp_n, active_v;
  logic [MAX_SETS-1:0] mask_clr;

  // Memories and their ports.
  logic [BIN_W-1:0] hist_mem [256];
  logic [7:0]       lev_mem  [256];
  logic [BIN_W-1:0] cnt_mem  [256];
  logic [7:0]       bord_mem [GD];
  logic [TOT_W-1:0] tot_mem  [GD];
  logic [8:0]       thr_mem  [TD];

  logic             hist_we, hist_re, lev_re, cnt_re, bord_we, bord_re, tot_we, tot_re;
  logic             lc_we, thr_we, thr_re;
  logic [7:0]       hist_wa, hist_ra, lc_wa, lev_ra, cnt_ra, bord_wd;
  logic [BIN_W-1:0] hist_wd, hist_rd, cnt_rd;
  logic [7:0]       lev_rd, bord_rd;
  logic [AW-1:0]    bord_wa, bord_ra, tot_wa, tot_ra;
  logic [TOT_W-1:0] tot_wd, tot_rd;
  logic [CW-1:0]    thr_wa, thr_ra_a, thr_ra_b;
  logic [8:0]       thr_wd, thr_rd_a, thr_rd_b;
  logic [TCW-1:0]   lo_i, hi_i;

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (lc_we) begin
      lev_mem[lc_wa] <= idx[7:0];
      cnt_mem[lc_wa] <= hist_rd;
    end
    if (lev_re) lev_rd <= lev_mem[lev_ra];
    if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (bord_we) bord_mem[bord_wa] <= bord_wd;
    if (bord_re) bord_rd <= bord_mem[bord_ra];
    if (tot_we) tot_mem[tot_wa] <= tot_wd;
    if (tot_re) tot_rd <= tot_mem[tot_ra];
  end

  always_ff @(posedge clk) begin
    if (thr_we) thr_mem[thr_wa] <= thr_wd;
    if (thr_re) begin
      thr_rd_a <= thr_mem[thr_ra_a];
      thr_rd_b <= thr_mem[thr_ra_b];
    end
  end

  // Derived values used by several steps.
  always_comb begin
    if (cfg_sets == 5'd0) clamp_n = AW'(1);
    else if (int'(cfg_sets) > MAX_SETS) clamp_n = AW'(MAX_SETS);
    else clamp_n = AW'(cfg_sets);
    nb     = CW'(nsets) + CW'(1);
    nbm1   = CW'(nsets);
    k      = CW'(idx) + (rev ? CW'(1) : CW'(0));
    m_v    = grouped ? nb : CW'(ct);
    pre_v  = rev ? (m_v < nb) : !bin0;
    s_v    = m + CW'(pre);
    post_v = !rev && (s_v < nb);
    tot_v  = TCW'(s_v) + TCW'(post_v);
    active_v = (tot_v < TCW'(nb)) ? AW'(tot_v - TCW'(1)) : nsets;
    next9  = (gi + CW'(1) < nb) ? {1'b0, bord_rd} : ct;
    b1     = {1'b0, cur_b} + 9'd1;
    skip   = (b1 >= ct) || (b1 == next9) || (left_r > right_r);
    t_val  = (k == m) ? LEVEL_END : {1'b0, lev_rd};
    top    = total - TCW'(1);
    hit    = ({1'b0, gray} >= thr_rd_a) && ({1'b0, gray} < thr_rd_b);
    mask_clr = mask;
    mask_clr[ei] = 1'b0;
  end

  // Band bounds of set ei under the current modes.
  always_comb begin
    if (rev) begin
      lo_i = top - TCW'(ei) - TCW'(1);
      hi_i = incl ? top : top - TCW'(ei);
    end else begin
      lo_i = incl ? '0 : TCW'(ei);
      hi_i = TCW'(ei) + TCW'(1);
    end
    thr_ra_a = CW'(lo_i);
    thr_ra_b = CW'(hi_i);
  end

  // Memory port control per operation.
  always_comb begin
    hist_we = 1'b0; hist_re = 1'b0; hist_wa = idx[7:0]; hist_ra = idx[7:0]; hist_wd = '0;
    lc_we = 1'b0; lc_wa = ct[7:0];
    lev_re = 1'b0; lev_ra = grouped ? bord_rd : 8'(k);
    cnt_re = 1'b0; cnt_ra = idx[7:0];
    bord_we = 1'b0; bord_wa = AW'(idx); bord_wd = idx[7:0];
    bord_re = 1'b0; bord_ra = '0;
    tot_we = 1'b0; tot_wa = AW'(idx); tot_wd = TOT_W'(cnt_rd);
    tot_re = 1'b0; tot_ra = '0;
    thr_we = 1'b0; thr_wa = '0; thr_wd = '0;
    thr_re = 1'b0;
    case (cmd.op)
      OP_CLEAR: hist_we = 1'b1;
      OP_CNT_RD: begin
        hist_re = 1'b1;
        hist_ra = gray;
      end
      OP_CNT_WR: begin
        hist_we = 1'b1;
        hist_wa = gray;
        hist_wd = (hist_rd == BIN_MAX) ? hist_rd : hist_rd + BIN_W'(1);
      end
      OP_SCAN_RD: begin
        hist_re = 1'b1;
        hist_we = 1'b1;
      end
      OP_SCAN_WR: lc_we = (hist_rd != '0);
      OP_INIT_RD: cnt_re = 1'b1;
      OP_INIT_WR: begin
        bord_we = (idx <= 9'(nbm1));
        tot_we  = (idx < 9'(nbm1));
      end
      OP_INIT_END: begin
        tot_we = 1'b1;
        tot_wa = AW'(nbm1);
        tot_wd = prev_tot;
      end
      OP_G_START: begin
        bord_re = 1'b1;
        bord_ra = AW'(1);
        tot_re  = 1'b1;
      end
      OP_G_RD: begin
        bord_re = 1'b1;
        bord_ra = (gi + CW'(1) < nb) ? AW'(gi + CW'(1)) : AW'(gi);
        tot_re  = 1'b1;
        tot_ra  = AW'(gi);
        cnt_re  = 1'b1;
        cnt_ra  = cur_b;
      end
      OP_G_CALC: begin
        tot_we  = 1'b1;
        tot_wa  = AW'(gi - CW'(1));
        tot_wd  = skip ? prev_tot : left_r;
        bord_we = !skip;
        bord_wa = AW'(gi);
        bord_wd = b1[7:0];
      end
      OP_G_END: begin
        tot_we = 1'b1;
        tot_wa = AW'(nbm1);
        tot_wd = prev_tot;
      end
      OP_T_START: thr_we = pre_v;
      OP_T_RD1: begin
        bord_re = 1'b1;
        bord_ra = (k < nb) ? AW'(k) : '0;
      end
      OP_T_RD2: lev_re = 1'b1;
      OP_T_WR: begin
        thr_we = 1'b1;
        thr_wa = CW'(idx) + CW'(pre);
        thr_wd = t_val;
      end
      OP_T_POST: begin
        thr_we = post_v;
        thr_wa = s_v;
        thr_wd = LEVEL_END;
      end
      OP_M_RD, OP_E_SCAN: thr_re = 1'b1;
      default: ;
    endcase
  end

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      ct        <= '0;
      total     <= '0;
      active    <= '0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: idx <= idx + 9'd1;
        OP_SCAN_INIT: begin
          idx   <= '0;
          ct    <= '0;
          bin0  <= 1'b0;
          nsets <= clamp_n;
        end
        OP_SCAN_WR: begin
          if (hist_rd != '0) ct <= ct + 9'd1;
          if (idx == 9'd0) bin0 <= (hist_rd != '0);
          idx <= idx + 9'd1;
        end
        OP_DECIDE: begin
          idx     <= '0;
          grouped <= (ct > 9'(nb));
          if (ct == 9'd0) begin
            total  <= '0;
            active <= '0;
          end
        end
        OP_INIT_WR: begin
          if (idx == 9'(nbm1)) prev_tot <= TOT_W'(cnt_rd);
          else if (idx > 9'(nbm1)) prev_tot <= prev_tot + TOT_W'(cnt_rd);
          idx <= idx + 9'd1;
        end
        OP_G_START: begin
          gi    <= CW'(1);
          moved <= 1'b0;
        end
        OP_G_LOAD: begin
          prev_tot <= tot_rd;
          cur_b    <= bord_rd;
        end
        OP_G_SUM: begin
          left_r  <= prev_tot + TOT_W'(cnt_rd);
          right_r <= tot_rd - TOT_W'(cnt_rd);
        end
        OP_G_CALC: begin
          if (skip) begin
            prev_tot <= tot_rd;
          end else begin
            prev_tot <= right_r;
            moved    <= 1'b1;
          end
          cur_b <= bord_rd;
          gi    <= gi + CW'(1);
        end
        OP_T_START: begin
          idx <= '0;
          m   <= m_v;
          pre <= pre_v;
        end
        OP_T_WR: idx <= idx + 9'd1;
        OP_T_POST: begin
          total  <= tot_v;
          active <= active_v;
        end
        OP_F_MASK: begin
          for (int b = 0; b < MAX_SETS; b++) begin
            mask[b] <= (b < int'(active));
          end
        end
        OP_M_START: begin
          ei   <= '0;
          mask <= '0;
        end
        OP_M_CALC: begin
          mask[ei] <= hit;
          ei       <= ei + EW'(1);
        end
        OP_E_START: ei <= '0;
        OP_E_SCAN: begin
          if (!mask[ei]) ei <= ei + EW'(1);
        end
        OP_E_LOAD: begin
          out_valid <= 1'b1;
          mask      <= mask_clr;
        end
        OP_E_WAIT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            ei        <= ei + EW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_E_LOAD) begin
      result_kind <= (req == REQ_CLASSIFY);
      set_index   <= 4'(ei);
      band_low    <= thr_rd_a;
      band_high   <= thr_rd_b;
      last_item   <= (mask_clr == '0);
      if (req == REQ_CLASSIFY) begin
        coord_x <= $signed({5'b0, col}) + $signed({xoff[15], xoff});
        coord_y <= $signed({5'b0, row}) + $signed({yoff[15], yoff});
      end else begin
        coord_x <= '0;
        coord_y <= '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    st.idx_last    = (idx[7:0] == 8'hFF);
    st.ct_zero     = (ct == 9'd0);
    st.grouped     = (ct > 9'(nb));
    st.init_last   = (idx == ct - 9'd1);
    st.g_last      = (gi == nbm1);
    st.moved       = moved;
    st.t_last      = (idx == 9'(m) - 9'd1);
    st.active_zero = (active == '0);
    st.m_last      = (AW'(ei) == active - AW'(1));
    st.mask_zero   = (mask == '0);
    st.mask_hit    = mask[ei];
    st.out_taken   = out_valid && !out_stall;
  end

endmodule

>>> hdl/gray_band_threshold_extractor_unit.sv
`timescale 1ns / 1ps
// Count request: one read-modify-write of the histogram memory.
// Classify request: the bands of the active sets are tested, then one beat per hit band.
// Finish request: a walk over the histogram, then the nonempty levels seed the groups,
// balancing passes run while a border moves, the thresholds are written, then the band beats.
// One item is in work at a time. Reset is synchronous; afterwards a pass clears
// the histogram with input stalled.
module gray_band_threshold_extractor_unit import gbte_pkg::*; #(
  parameter int MAX_SETS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [23:0]        pixel_color,
  input  logic [11:0]        pixel_column,
  input  logic [11:0]        pixel_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [3:0]         set_index,
  output logic [8:0]         band_low,
  output logic [8:0]         band_high,
  output logic signed [16:0] coord_x,
  output logic signed [16:0] coord_y,
  output logic               last_item
);

  cmd_t    cmd;
  status_t st;

  gbte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  gbte_dp #(.MAX_SETS(MAX_SETS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .pixel_color  (pixel_color),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .result_kind  (result_kind),
    .set_index    (set_index),
    .band_low     (band_low),
    .band_high    (band_high),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .last_item    (last_item)
  );

`ifndef SYNTHESIS
  // No new request is taken while a result beat is pending.
  a_no_accept_on_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input accepted while result pending");

  // Band beats carry no coordinates.
  a_band_coords: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result_kind) |-> (coord_x == 17'sd0 && coord_y == 17'sd0))
    else $error("band beat with coordinates");

  // Thresholds rise strictly, so every band is nonempty.
  a_band_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (band_low < band_high)) else $error("empty band emitted");
`endif

endmodule

>>> tb/tb_gray_band_threshold_extractor_unit.sv
`timescale 1ns / 1ps
module tb_gray_band_threshold_extractor_unit;
  import gbte_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int SETTLE_CYCLES = 1200;
  localparam int SETS_CAP = 16;

  typedef struct packed {
    logic              kind;
    logic [3:0]        set;
    logic [8:0]        lo;
    logic [8:0]        hi;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic              last;
  } band_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_SETS;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         req_type = REQ_COUNT;
  logic [23:0]        pixel_color = '0;
  logic [11:0]        pixel_column = '0;
  logic [11:0]        pixel_row = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               result_kind;
  logic [3:0]         set_index;
  logic [8:0]         band_low;
  logic [8:0]         band_high;
  logic signed [16:0] coord_x;
  logic signed [16:0] coord_y;
  logic               last_item;

  gray_band_threshold_extractor_unit u_top (.*);

  // Mirror of the block state and registers.
  int unsigned        hist_bins[256];
  int                 thr_levels[18];
  int                 thr_count;
  int                 live_sets;
  logic [4:0]         sets_reg;
  logic               incl_reg;
  logic               rev_reg;
  logic signed [15:0] xoff_reg;
  logic signed [15:0] yoff_reg;

  band_beat_t pending_beats[$];
  int         error_count = 0;
  int         beats_seen = 0;
  int         items_sent = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         cycle_count = 0;

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int luma(logic [23:0] c);
    return (77 * c[23:16] + 154 * c[15:8] + 25 * c[7:0]) >> 8;
  endfunction

  function automatic void band_edges(int i, output int lo, output int hi);
    int top;
    top = thr_count - 1;
    if (rev_reg) begin
      lo = thr_levels[top - i - 1];
      hi = incl_reg ? thr_levels[top] : thr_levels[top - i];
    end else begin
      lo = incl_reg ? thr_levels[0] : thr_levels[i];
      hi = thr_levels[i + 1];
    end
  endfunction

  // Finish: balance the nonempty levels into groups and emit the bands.
  function automatic void close_histogram();
    int          n, ct, nb, i, b, nx, lo, hi;
    int          lv[256];
    longint      cnt[256];
    int          bd[17];
    longint      tot[17];
    longint      lft, rgt;
    bit          moved;
    band_beat_t  bt;
    n = sets_reg;
    ct = 0;
    if (n < 1) n = 1;
    if (n > SETS_CAP) n = SETS_CAP;
    for (i = 0; i < 256; i++) begin
      if (hist_bins[i] != 0) begin
        lv[ct] = i;
        cnt[ct] = hist_bins[i];
        ct++;
      end
    end
    if (ct > n + 1) begin
      nb = n + 1;
      for (i = 0; i < nb; i++) begin
        bd[i] = i;
        tot[i] = cnt[i];
      end
      for (i = nb; i < ct; i++) tot[nb - 1] += cnt[i];
      do begin
        moved = 0;
        for (i = 1; i < nb; i++) begin
          b = bd[i];
          nx = (i + 1 < nb) ? bd[i + 1] : ct;
          if (b + 1 >= ct || b + 1 == nx) continue;
          rgt = tot[i] - cnt[b];
          lft = tot[i - 1] + cnt[b];
          if (lft > rgt) continue;
          tot[i] = rgt;
          tot[i - 1] = lft;
          bd[i] = b + 1;
          moved = 1;
        end
      end while (moved);
      for (i = 0; i < nb; i++) thr_levels[i] = lv[bd[i]];
      ct = nb;
    end else begin
      for (i = 0; i < ct; i++) thr_levels[i] = lv[i];
    end
    if (rev_reg && ct > 0) begin
      for (i = 1; i < ct; i++) thr_levels[i - 1] = thr_levels[i];
      thr_levels[ct - 1] = 256;
    end
    if (ct > 0 && thr_levels[0] > 0 && ct < n + 2 && (ct < n + 1 || !rev_reg)) begin
      for (i = ct; i > 0; i--) thr_levels[i] = thr_levels[i - 1];
      thr_levels[0] = 0;
      ct++;
    end
    if (ct > 0 && thr_levels[ct - 1] < 256 && ct < n + 2 && (ct < n + 1 || rev_reg)) begin
      thr_levels[ct] = 256;
      ct++;
    end
    thr_count = ct;
    if (ct == 0) n = 0;
    else if (ct < n + 1) n = ct - 1;
    live_sets = n;
    for (i = 0; i < n; i++) begin
      band_edges(i, lo, hi);
      bt = '{1'b0, 4'(i), 9'(lo), 9'(hi), 17'sd0, 17'sd0, (i + 1 == n)};
      pending_beats.push_back(bt);
    end
    foreach (hist_bins[j]) hist_bins[j] = 0;
  endfunction

  function automatic void classify_pixel(logic [23:0] c, logic [11:0] col, logic [11:0] row);
    int          g, i, lo, hi;
    int          hits[$];
    band_beat_t  bt;
    g = luma(c);
    for (i = 0; i < live_sets && i < SETS_CAP; i++) begin
      band_edges(i, lo, hi);
      if (g >= lo && g < hi) hits.push_back(i);
    end
    foreach (hits[k]) begin
      band_edges(hits[k], lo, hi);
      bt.kind = 1'b1;
      bt.set = 4'(hits[k]);
      bt.lo = 9'(lo);
      bt.hi = 9'(hi);
      bt.x = 17'(col) + 17'(xoff_reg);
      bt.y = 17'(row) + 17'(yoff_reg);
      bt.last = (k == hits.size() - 1);
      pending_beats.push_back(bt);
    end
  endfunction

  // Send one request beat and update the predicted results once it is taken.
  task automatic send_req(logic [1:0] kind, logic [23:0] c, logic [11:0] col, logic [11:0] row);
    int gap;
    req_type <= kind;
    pixel_color <= c;
    pixel_column <= col;
    pixel_row <= row;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    case (kind)
      REQ_COUNT: if (hist_bins[luma(c)] < 32'h1FFFFFF) hist_bins[luma(c)]++;
      REQ_FINISH: close_histogram();
      REQ_CLASSIFY: classify_pixel(c, col, row);
      default: ;
    endcase
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let every predicted beat arrive, then give the block time to go idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers, one per cycle; call only while idle.
  task automatic set_regs(logic [4:0] s, logic incl, logic rev, logic [15:0] xo, logic [15:0] yo);
    cfg_we <= 1'b1;
    cfg_index <= REG_SETS;  cfg_data <= 16'(s);    @(posedge clk);
    cfg_index <= REG_INCL;  cfg_data <= 16'(incl); @(posedge clk);
    cfg_index <= REG_REV;   cfg_data <= 16'(rev);  @(posedge clk);
    cfg_index <= REG_XOFF;  cfg_data <= xo;        @(posedge clk);
    cfg_index <= REG_YOFF;  cfg_data <= yo;        @(posedge clk);
    cfg_we <= 1'b0;
    sets_reg = s;
    incl_reg = incl;
    rev_reg = rev;
    xoff_reg = xo;
    yoff_reg = yo;
  endtask

  function automatic logic [23:0] rand_color();
    case ($urandom_range(3))
      0: return {8'($urandom_range(3) * 85), 8'($urandom_range(3) * 85), 8'h00};
      1: return 24'($urandom_range(24'hFFFFFF));
      default: return {3{8'($urandom_range(255))}};
    endcase
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    band_beat_t want;
    out_stall <= ($urandom_range(99) < rx_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: set %0d low %0d high %0d", set_index, band_low, band_high);
        error_count++;
      end else begin
        want = pending_beats.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          error_count++;
        end
        if (set_index !== want.set) begin
          $error("set_index: expected %0d, got %0d", want.set, set_index);
          error_count++;
        end
        if (band_low !== want.lo) begin
          $error("band_low: expected %0d, got %0d", want.lo, band_low);
          error_count++;
        end
        if (band_high !== want.hi) begin
          $error("band_high: expected %0d, got %0d", want.hi, band_high);
          error_count++;
        end
        if (coord_x !== want.x) begin
          $error("coord_x: expected %0d, got %0d", want.x, coord_x);
          error_count++;
        end
        if (coord_y !== want.y) begin
          $error("coord_y: expected %0d, got %0d", want.y, coord_y);
          error_count++;
        end
        if (last_item !== want.last) begin
          $error("last_item: expected %0d, got %0d", want.last, last_item);
          error_count++;
        end
      end
    end
  end

  // Corner cases: empty state, ignored requests, color extremes, set count limits.
  task automatic test_directed();
    send_req(REQ_CLASSIFY, 24'h808080, 12'd0, 12'd0);
    send_req(REQ_FINISH, 24'h0, 12'd0, 12'd0);
    send_req(REQ_RSVD, 24'hFFFFFF, 12'hFFF, 12'hFFF);
    send_req(REQ_COUNT, 24'h000000, 12'd0, 12'd0);
    send_req(REQ_COUNT, 24'hFFFFFF, 12'hFFF, 12'hFFF);
    send_req(REQ_COUNT, 24'hFF0000, 12'd1, 12'd2);
    send_req(REQ_COUNT, 24'h00FF00, 12'd3, 12'd4);
    send_req(REQ_COUNT, 24'h0000FF, 12'd5, 12'd6);
    send_req(REQ_FINISH, 24'h0, 12'd0, 12'd0);
    send_req(REQ_CLASSIFY, 24'hFFFFFF, 12'hFFF, 12'hFFF);
    send_req(REQ_CLASSIFY, 24'h000000, 12'd0, 12'd0);
    drain();
    // Requested sets of zero and above the cap, with offset extremes.
    set_regs(5'd0, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
    send_req(REQ_COUNT, 24'h404040, 12'd7, 12'd7);
    send_req(REQ_COUNT, 24'hC0C0C0, 12'd7, 12'd7);
    send_req(REQ_FINISH, 24'h0, 12'd0, 12'd0);
    send_req(REQ_CLASSIFY, 24'hC0C0C0, 12'hFFF, 12'd0);
    drain();
    set_regs(5'd31, 1'b0, 1'b0, 16'h8000, 16'h7FFF);
    repeat (5) send_req(REQ_COUNT, rand_color(), 12'd0, 12'd0);
    send_req(REQ_FINISH, 24'h0, 12'd0, 12'd0);
    send_req(REQ_CLASSIFY, 24'h123456, 12'd0, 12'hFFF);
    drain();
    // Register change after finish: stored thresholds, new modes.
    set_regs(5'd16, 1'b1, 1'b1, 16'h0000, 16'h0000);
    send_req(REQ_CLASSIFY, 24'h404040, 12'd9, 12'd9);
    drain();
  endtask

  // Random rounds of counting, finishing and classifying.
  task automatic test_rounds(int rounds);
    int r, k, cnt, cls;
    for (r = 0; r < rounds; r++) begin
      case ($urandom_range(3))
        0: set_regs(5'd1, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        1: set_regs(5'd16, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        default: set_regs(5'($urandom_range(31)), 1'($urandom), 1'($urandom),
                          16'($urandom), 16'($urandom));
      endcase
      cnt = $urandom_range(30, 4);
      cls = $urandom_range(12, 4);
      for (k = 0; k < cnt; k++) begin
        if ($urandom_range(19) == 0)
          send_req(REQ_RSVD, 24'($urandom), 12'($urandom), 12'($urandom));
        else
          send_req(REQ_COUNT, rand_color(), 12'($urandom), 12'($urandom));
      end
      send_req(REQ_FINISH, 24'($urandom), 12'($urandom), 12'($urandom));
      if ($urandom_range(3) == 0) begin
        drain();
        set_regs(sets_reg, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      end
      for (k = 0; k < cls; k++)
        send_req(REQ_CLASSIFY, rand_color(), 12'($urandom), 12'($urandom));
      drain();
    end
  endtask

  initial begin
    foreach (hist_bins[j]) hist_bins[j] = 0;
    foreach (thr_levels[j]) thr_levels[j] = 0;
    thr_count = 0;
    live_sets = 0;
    sets_reg = 5'd1;
    incl_reg = 1'b0;
    rev_reg = 1'b0;
    xoff_reg = '0;
    yoff_reg = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    tx_idle_pct = 11;
    rx_idle_pct = 64;
    test_rounds(5);
    tx_idle_pct = 64;
    rx_idle_pct = 11;
    test_rounds(5);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_rounds(5);
    drain();
    $display("Run covered %0d requests and %0d result beats over sender and receiver idling",
             items_sent, beats_seen);
    $display("with set counts from 0 to 31, both modes and offset extremes.");
    if (error_count == 0 && pending_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
